@@ sv/pgoc_pkg.sv @@
`default_nettype none
package pgoc_pkg;

   localparam logic [1:0] OP_POINT = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;
   localparam logic [1:0] OP_LOAD  = 2'd3;

   localparam logic [1:0] RS_NONE  = 2'd0;
   localparam logic [1:0] RS_STOP  = 2'd1;
   localparam logic [1:0] RS_WARN  = 2'd2;
   localparam logic [1:0] RS_CLEAR = 2'd3;

   localparam logic [1:0] ZK_STOP = 2'd1;
   localparam logic [1:0] ZK_WARN = 2'd2;

   localparam logic [2:0] CSR_DETECT = 3'd0;
   localparam logic [2:0] CSR_NOISE  = 3'd1;
   localparam logic [2:0] CSR_OVER   = 3'd2;
   localparam logic [2:0] CSR_ELEV   = 3'd3;
   localparam logic [2:0] CSR_LOW    = 3'd4;
   localparam logic [2:0] CSR_HIGH   = 3'd5;
   localparam logic [2:0] CSR_TOL    = 3'd6;

   localparam logic [15:0] EMPTY_H = 16'd10000;
   localparam logic [15:0] CNT_MAX = 16'hffff;

   typedef struct packed {
      logic [15:0] least;
      logic [15:0] points;
      logic [15:0] over;
      logic        warn;
   } grid_word_type;

   typedef struct packed {
      logic [1:0]  mask;
      logic [1:0]  poly;
      logic        guard;
      logic [15:0] base;
   } zone_word_type;

endpackage
`default_nettype wire

@@ sv/pgoc_ram.sv @@
`default_nettype none
module pgoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ sv/point_grid_obstacle_check.sv @@
// point item: one item at a time, through states DIV, FIX, ADDR, RC, RL, RD, RLD, EVAL, with
//   four reads of the grid memory (own cell and three neighbours) and a write back
// end frame and stopped-frame points: result the cycle after the transfer
// zone load: via state LOAD; start frame: clear sweep of (RES_X+1)*(RES_Z+1) cells, then result
// reset: clear sweep of both memories, (RES_X+1)*(RES_Z+1) cells, busy meanwhile
// the receiver cannot stall: each result strobe lasts one cycle
`default_nettype none
module point_grid_obstacle_check import pgoc_pkg::*; #(
   parameter int RES_X  = 256,
   parameter int RES_Z  = 256,
   parameter int BIN_MM = 10
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_op,
   input  wire logic [15:0]                  req_x_mm,
   input  wire logic [15:0]                  req_y_mm,
   input  wire logic [15:0]                  req_z_mm,
   input  wire logic [$clog2(RES_X+1)-1:0]   req_load_bin_x,
   input  wire logic [$clog2(RES_Z+1)-1:0]   req_load_bin_z,
   input  wire logic [1:0]                   req_mask_kind,
   input  wire logic [1:0]                   req_poly_kind,
   input  wire logic                         req_guard_flag,
   input  wire logic [15:0]                  req_base_height_mm,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [$clog2(RES_X+1)-1:0]        rsp_hit_x,
   output logic [$clog2(RES_Z+1)-1:0]        rsp_hit_z,
   output logic [15:0]                       rsp_hit_height_mm,
   input  wire logic                         csr_we,
   input  wire logic [2:0]                   csr_index,
   input  wire logic [15:0]                  csr_wdata
);
   localparam int BXW   = $clog2(RES_X+1);
   localparam int BZW   = $clog2(RES_Z+1);
   localparam int NZ    = RES_Z + 1;
   localparam int CELLS = (RES_X + 1) * (RES_Z + 1);
   localparam int CW    = $clog2(CELLS);
   localparam int QMAX  = ((RES_X > RES_Z) ? RES_X : RES_Z) * BIN_MM;
   localparam int QW    = $clog2(QMAX + 1);
   localparam int RECIP = (1 << QW) / BIN_MM;
   localparam int HALF  = (RES_X / 2) * BIN_MM;
   localparam int XLIM  = RES_X * BIN_MM;
   localparam int ZLIM  = RES_Z * BIN_MM;

   typedef enum logic [10:0] {
      S_IDLE = 11'b00000000001,
      S_CLR  = 11'b00000000010,
      S_DIV  = 11'b00000000100,
      S_FIX  = 11'b00000001000,
      S_ADDR = 11'b00000010000,
      S_RC   = 11'b00000100000,
      S_RL   = 11'b00001000000,
      S_RD   = 11'b00010000000,
      S_RLD  = 11'b00100000000,
      S_EVAL = 11'b01000000000,
      S_LOAD = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic        detect_ff;
   logic [15:0] noise_ff, overmin_ff, elev_ff, low_ff, high_ff;
   logic [9:0]  tol_ff;

   logic [CW-1:0] clr_ff, clr_in;
   logic          clr_all_ff, clr_all_in;
   logic          stopped_ff, stopped_in, pend_ff, pend_in;

   logic [15:0]           x_ff, y_ff, z_ff, base_ff;
   logic [BXW-1:0]        lx_ff;
   logic [BZW-1:0]        lz_ff;
   logic [1:0]            mk_ff, pk_ff;
   logic                  gf_ff;

   logic [QW-1:0]   qx_ff, qz_ff;
   logic            okx_ff, okz_ff;
   logic [2*QW-1:0] px_ff, pz_ff;
   logic [BXW-1:0]  xi_ff;
   logic [BZW-1:0]  zi_ff;
   logic [CW-1:0]   c_ff, cl_ff, cd_ff, cld_ff;
   logic            edge_ff;

   grid_word_type cur_ff;
   zone_word_type zone_ff;
   logic signed [31:0] lhs_ff, rhs_ff;
   logic [15:0] pc_ff, oc_ff, lh_ff;
   logic        low_l_ff, over_l_ff, warn_l_ff, low_d_ff, over_d_ff, warn_d_ff;
   logic        cond_ff;

   logic          rv_ff, rv_in;
   logic [1:0]    rs_ff, rs_in;
   logic [BXW-1:0] rx_ff, rx_in;
   logic [BZW-1:0] rz_ff, rz_in;
   logic [15:0]   rh_ff, rh_in;

   grid_word_type g_rdata, g_wdata;
   zone_word_type z_rdata, z_wdata;
   logic [CW-1:0] g_raddr, g_waddr, z_waddr;
   logic          g_we, z_we;

   logic accept;
   logic signed [31:0] qxs, qzs;
   logic [QW-1:0]  qax, qaz;
   logic [31:0]    remx, remz;
   logic [31:0]    cell_sum, load_sum;
   logic signed [16:0] diff;
   logic nb_low, nb_over, nb_warn, mark, stop_hit, warn_hit;
   logic [15:0] stop_h;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   pgoc_ram #(.WIDTH($bits(grid_word_type)), .DEPTH(CELLS)) u_grid (
      .clock(clock), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
      .raddr(g_raddr), .rdata(g_rdata)
   );

   pgoc_ram #(.WIDTH($bits(zone_word_type)), .DEPTH(CELLS)) u_zone (
      .clock(clock), .we(z_we), .waddr(z_waddr), .wdata(z_wdata),
      .raddr(c_ff), .rdata(z_rdata)
   );

   // address arithmetic
   assign qxs      = 32'($signed(x_ff)) + 32'(HALF);
   assign qzs      = 32'($signed(z_ff));
   assign qax      = QW'(px_ff >> QW);
   assign qaz      = QW'(pz_ff >> QW);
   assign remx     = 32'(qx_ff) - 32'(qax) * 32'(BIN_MM);
   assign remz     = 32'(qz_ff) - 32'(qaz) * 32'(BIN_MM);
   assign cell_sum = 32'(xi_ff) * 32'(NZ) + 32'(zi_ff);
   assign load_sum = 32'(lx_ff) * 32'(NZ) + 32'(lz_ff);
   assign diff     = 17'($signed(z_rdata.base)) - 17'($signed(y_ff));

   always_comb begin
      case (state_ff)
         S_RL:    g_raddr = cl_ff;
         S_RD:    g_raddr = cd_ff;
         S_RLD:   g_raddr = cld_ff;
         default: g_raddr = c_ff;
      endcase
   end

   // neighbour decision, last neighbour straight from the memory
   always_comb begin
      nb_low   = low_l_ff && low_d_ff && ($signed(g_rdata.least) < $signed(elev_ff));
      nb_over  = over_l_ff && over_d_ff && (g_rdata.over > overmin_ff);
      nb_warn  = warn_l_ff || warn_d_ff || g_rdata.warn;
      mark     = 1'b0;
      stop_hit = 1'b0;
      warn_hit = 1'b0;
      stop_h   = lh_ff;
      if (cond_ff) begin
         if (zone_ff.mask == ZK_STOP || zone_ff.mask == ZK_WARN) begin
            if (!edge_ff && nb_low) begin
               mark = 1'b1;
               if (nb_warn) begin
                  stop_hit = (zone_ff.mask == ZK_STOP);
                  warn_hit = (zone_ff.mask == ZK_WARN);
               end
            end
         end else if (oc_ff > overmin_ff && zone_ff.guard) begin
            if (!edge_ff && nb_over &&
                (zone_ff.poly == ZK_STOP || zone_ff.poly == ZK_WARN)) begin
               mark = 1'b1;
               stop_h = y_ff;
               if (nb_warn) begin
                  stop_hit = (zone_ff.poly == ZK_STOP);
                  warn_hit = (zone_ff.poly == ZK_WARN);
               end
            end
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      clr_all_in = clr_all_ff;
      stopped_in = stopped_ff;
      pend_in    = pend_ff;
      rv_in      = 1'b0;
      rs_in      = RS_NONE;
      rx_in      = '0;
      rz_in      = '0;
      rh_in      = '0;
      g_we       = 1'b0;
      g_waddr    = c_ff;
      g_wdata    = '{least: lh_ff, points: pc_ff, over: oc_ff, warn: cur_ff.warn | mark};
      z_we       = 1'b0;
      z_waddr    = CW'(load_sum);
      z_wdata    = '{mask: mk_ff, poly: pk_ff, guard: gf_ff, base: base_ff};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_START: begin
                     state_in   = S_CLR;
                     clr_in     = '0;
                     clr_all_in = 1'b0;
                  end
                  OP_END: begin
                     rv_in = 1'b1;
                     if (!stopped_ff) begin
                        rs_in      = pend_ff ? RS_WARN : RS_CLEAR;
                        pend_in    = 1'b0;
                        stopped_in = 1'b1;
                     end
                  end
                  OP_LOAD: state_in = S_LOAD;
                  default: begin
                     if (stopped_ff) begin
                        rv_in = 1'b1;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
               endcase
            end
         end
         S_CLR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            g_wdata = '{least: EMPTY_H, points: '0, over: '0, warn: 1'b0};
            z_we    = clr_all_ff;
            z_waddr = clr_ff;
            z_wdata = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == CW'(CELLS - 1)) begin
               state_in   = S_IDLE;
               stopped_in = 1'b0;
               rv_in      = !clr_all_ff;
            end
         end
         S_LOAD: begin
            z_we     = (32'(lx_ff) <= 32'(RES_X)) && (32'(lz_ff) <= 32'(RES_Z));
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         S_DIV:  state_in = S_FIX;
         S_FIX:  state_in = S_ADDR;
         S_ADDR: state_in = S_RC;
         S_RC:   state_in = S_RL;
         S_RL:   state_in = S_RD;
         S_RD:   state_in = S_RLD;
         S_RLD:  state_in = S_EVAL;
         S_EVAL: begin
            g_we     = 1'b1;
            rv_in    = 1'b1;
            state_in = S_IDLE;
            if (stop_hit) begin
               rs_in      = RS_STOP;
               rx_in      = xi_ff;
               rz_in      = zi_ff;
               rh_in      = stop_h;
               stopped_in = 1'b1;
            end
            if (warn_hit) begin
               pend_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_ff     <= '0;
         clr_all_ff <= 1'b1;
         stopped_ff <= 1'b0;
         pend_ff    <= 1'b0;
         rv_ff      <= 1'b0;
         detect_ff  <= 1'b0;
         noise_ff   <= 16'd10;
         overmin_ff <= 16'd3;
         elev_ff    <= 16'd300;
         low_ff     <= 16'hfd44;
         high_ff    <= 16'd1000;
         tol_ff     <= 10'd10;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_all_ff <= clr_all_in;
         stopped_ff <= stopped_in;
         pend_ff    <= pend_in;
         rv_ff      <= rv_in;
         if (csr_we) begin
            case (csr_index)
               CSR_DETECT: detect_ff  <= csr_wdata[0];
               CSR_NOISE:  noise_ff   <= csr_wdata;
               CSR_OVER:   overmin_ff <= csr_wdata;
               CSR_ELEV:   elev_ff    <= csr_wdata;
               CSR_LOW:    low_ff     <= csr_wdata;
               CSR_HIGH:   high_ff    <= csr_wdata;
               CSR_TOL:    tol_ff     <= csr_wdata[9:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rs_ff <= rs_in;
      rx_ff <= rx_in;
      rz_ff <= rz_in;
      rh_ff <= rh_in;
      if (accept) begin
         x_ff    <= req_x_mm;
         y_ff    <= req_y_mm;
         z_ff    <= req_z_mm;
         lx_ff   <= req_load_bin_x;
         lz_ff   <= req_load_bin_z;
         mk_ff   <= req_mask_kind;
         pk_ff   <= req_poly_kind;
         gf_ff   <= req_guard_flag;
         base_ff <= req_base_height_mm;
      end
      if (state_ff == S_DIV) begin
         okx_ff <= (qxs > 0) && (qxs < XLIM);
         okz_ff <= (qzs > 0) && (qzs < ZLIM);
         qx_ff  <= QW'(qxs);
         qz_ff  <= QW'(qzs);
         px_ff  <= (2*QW)'(qxs[QW-1:0]) * (2*QW)'(RECIP);
         pz_ff  <= (2*QW)'(qzs[QW-1:0]) * (2*QW)'(RECIP);
      end
      if (state_ff == S_FIX) begin
         xi_ff <= okx_ff ? BXW'(qax + QW'(remx >= 32'(BIN_MM))) : '0;
         zi_ff <= okz_ff ? BZW'(qaz + QW'(remz >= 32'(BIN_MM))) : '0;
      end
      if (state_ff == S_ADDR) begin
         edge_ff <= (xi_ff == '0) || (zi_ff == '0);
         c_ff    <= CW'(cell_sum);
         if ((xi_ff == '0) || (zi_ff == '0)) begin
            cl_ff  <= CW'(cell_sum);
            cd_ff  <= CW'(cell_sum);
            cld_ff <= CW'(cell_sum);
         end else begin
            cl_ff  <= CW'(cell_sum - 32'(NZ));
            cd_ff  <= CW'(cell_sum - 32'd1);
            cld_ff <= CW'(cell_sum - 32'(NZ) - 32'd1);
         end
      end
      if (state_ff == S_RL) begin
         cur_ff  <= g_rdata;
         zone_ff <= z_rdata;
         lhs_ff  <= 32'(diff) * 32'(RES_Z);
         rhs_ff  <= $signed(32'(zi_ff) * 32'(tol_ff));
      end
      if (state_ff == S_RD) begin
         low_l_ff  <= $signed(g_rdata.least) < $signed(elev_ff);
         over_l_ff <= g_rdata.over > overmin_ff;
         warn_l_ff <= g_rdata.warn;
         pc_ff     <= (cur_ff.points != CNT_MAX) ? cur_ff.points + 16'd1 : cur_ff.points;
         oc_ff     <= (lhs_ff > rhs_ff && cur_ff.over != CNT_MAX) ?
                      cur_ff.over + 16'd1 : cur_ff.over;
         lh_ff     <= ($signed(y_ff) < $signed(cur_ff.least)) ? y_ff : cur_ff.least;
      end
      if (state_ff == S_RLD) begin
         low_d_ff  <= $signed(g_rdata.least) < $signed(elev_ff);
         over_d_ff <= g_rdata.over > overmin_ff;
         warn_d_ff <= g_rdata.warn;
         cond_ff   <= detect_ff && ($signed(lh_ff) < $signed(elev_ff)) &&
                      ($signed(lh_ff) < $signed(high_ff)) &&
                      ($signed(lh_ff) > $signed(low_ff)) && (pc_ff > noise_ff);
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = rs_ff;
   assign rsp_hit_x         = rx_ff;
   assign rsp_hit_z         = rz_ff;
   assign rsp_hit_height_mm = rh_ff;
endmodule
`default_nettype wire

@@ sv/pgoc_checker.sv @@
`default_nettype none
module pgoc_checker import pgoc_pkg::*; #(
   parameter int RES_X = 256,
   parameter int RES_Z = 256
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       start,
   input wire logic                       busy,
   input wire logic                       rsp_valid,
   input wire logic [1:0]                 rsp_status,
   input wire logic [$clog2(RES_X+1)-1:0] rsp_hit_x,
   input wire logic [$clog2(RES_Z+1)-1:0] rsp_hit_z
);
   // clear sweep after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   // a result always comes with the block ready again
   a_idle_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // hit bins only with a stop
   a_hit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != RS_STOP) |-> (rsp_hit_x == '0 && rsp_hit_z == '0))
      else $error("hit bins without stop");

   // a stop never follows directly on a transfer
   a_stop_late: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !(rsp_valid && rsp_status == RS_STOP))
      else $error("stop too early");
endmodule

bind point_grid_obstacle_check pgoc_checker #(.RES_X(RES_X), .RES_Z(RES_Z)) u_pgoc_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_hit_x(rsp_hit_x), .rsp_hit_z(rsp_hit_z)
);
`default_nettype wire
